/* design/afrpid_pkg.sv */
package afrpid_pkg;

    localparam int InWidth   = 48;
    localparam int OutWidth  = 16;
    localparam int ErrWidth  = 13;
    localparam int RateWidth = 14;
    localparam int SumWidth  = 24;
    localparam int GainWidth = 8;
    localparam int ProdWidth = 32;
    localparam int TermWidth = 25;
    localparam int TotWidth  = 27;
    localparam int NumStages = 5;

    localparam logic [7:0]  TrimMid     = 8'd128;
    localparam logic [7:0]  TrimLow     = 8'd96;
    localparam logic [7:0]  TrimHigh    = 8'd160;
    localparam logic [31:0] Div255Recip = 32'h8080_8081;
    localparam int          RecipShift  = 39;

    typedef struct packed {
        logic prod_en;
        logic quot_en;
    } term_ctl_t;

endpackage

/* design/afrpid_term.sv */
module afrpid_term (
    input  logic                                      clk,
    input  afrpid_pkg::term_ctl_t                     ctl,
    input  logic signed [afrpid_pkg::SumWidth-1:0]    value,
    input  logic        [afrpid_pkg::GainWidth-1:0]   gain,
    output logic signed [afrpid_pkg::TermWidth-1:0]   term
);
    import afrpid_pkg::*;

    logic signed [ProdWidth:0]     prod_full;
    logic signed [ProdWidth-1:0]   prod_reg;
    logic signed [ProdWidth-1:0]   prod_next;
    logic        [ProdWidth-2:0]   mag;
    logic        [62:0]            recip_prod;
    logic        [SumWidth-1:0]    quot;
    logic signed [TermWidth-1:0]   quot_reg;
    logic signed [TermWidth-1:0]   quot_next;

    // The product of the term and its gain always fits in 32 signed bits.
    assign prod_full = (ProdWidth+1)'(value) * (ProdWidth+1)'($signed({1'b0, gain}));
    assign prod_next = $signed(prod_full[ProdWidth-1:0]);

    // Division by 255 truncates toward zero, so it works on the magnitude.
    assign mag        = prod_reg[ProdWidth-1] ? (ProdWidth-1)'(-prod_reg)
                                              : prod_reg[ProdWidth-2:0];
    assign recip_prod = 63'(mag) * 63'(Div255Recip);
    assign quot       = recip_prod[RecipShift +: SumWidth];
    assign quot_next  = prod_reg[ProdWidth-1] ? -$signed({1'b0, quot})
                                              : $signed({1'b0, quot});

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.quot_en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign term = quot_reg;

endmodule

/* design/afr_pid_fuel_trim_core.sv */
// Closed-loop air-fuel-ratio PID trim. The block takes one beat per clock
// while the output side does not stall and returns one beat, in order,
// per input beat. The integrator and the previous error are updated
// by a single add-and-saturate at the input, which is what lets the next
// beat follow in the very next cycle; the gain products, the divisions by
// 255 and the final clamp run in the pipeline behind it. A beat with
// enable low changes no state and returns the last trim with updated low.
module afr_pid_fuel_trim_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [afrpid_pkg::GainWidth-1:0]   cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // enable, target_afr[11:0], measured_afr[11:0], prop_gain[7:0],
    // integ_gain[7:0], zero fill
    input  logic [afrpid_pkg::InWidth-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fuel_trim[7:0], updated, zero fill
    output logic [afrpid_pkg::OutWidth-1:0]    m_axis_tdata
);
    import afrpid_pkg::*;

    logic                          in_enable;
    logic [11:0]                   in_target;
    logic [11:0]                   in_measured;
    logic [GainWidth-1:0]          in_pg;
    logic [GainWidth-1:0]          in_ig;
    logic                          s_accept;

    logic [GainWidth-1:0]          deriv_gain_reg;
    logic signed [SumWidth-1:0]    error_sum_reg;
    logic signed [ErrWidth-1:0]    last_error_reg;
    logic [7:0]                    trim_hold_reg;

    logic signed [ErrWidth-1:0]    err_next;
    logic signed [SumWidth:0]      acc_wide;
    logic signed [SumWidth-1:0]    acc_next;
    logic signed [RateWidth-1:0]   rate_next;

    logic [NumStages-1:0]          vld_reg;
    logic [NumStages-1:0]          can_load;
    logic [NumStages-1:0]          load;

    logic                          en1_reg;
    logic signed [ErrWidth-1:0]    err1_reg;
    logic signed [SumWidth-1:0]    acc1_reg;
    logic signed [RateWidth-1:0]   rate1_reg;
    logic [GainWidth-1:0]          pg1_reg;
    logic [GainWidth-1:0]          ig1_reg;
    logic                          en2_reg;
    logic                          en3_reg;
    logic                          en4_reg;
    logic signed [TotWidth-1:0]    sum4_reg;
    logic signed [TotWidth-1:0]    sum4_next;
    logic [7:0]                    trim_out_reg;
    logic                          upd_out_reg;

    term_ctl_t                     term_ctl;
    logic signed [TermWidth-1:0]   term_p;
    logic signed [TermWidth-1:0]   term_i;
    logic signed [TermWidth-1:0]   term_d;

    logic signed [TotWidth-1:0]    sum_adj;
    logic signed [TotWidth-1:0]    sum_div;
    logic [7:0]                    trim_next;
    logic [7:0]                    trim_out_next;

    assign in_enable   = s_axis_tdata[0];
    assign in_target   = s_axis_tdata[12:1];
    assign in_measured = s_axis_tdata[24:13];
    assign in_pg       = s_axis_tdata[32:25];
    assign in_ig       = s_axis_tdata[40:33];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        can_load[NumStages-1] = !vld_reg[NumStages-1] || m_axis_tready;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            can_load[k] = !vld_reg[k] || can_load[k+1];
        end
        load[0] = can_load[0] && s_axis_tvalid;
        for (int k = 1; k < NumStages; k++)
        begin
            load[k] = can_load[k] && vld_reg[k-1];
        end
    end

    assign s_axis_tready = can_load[0];
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign err_next  = $signed({1'b0, in_target}) - $signed({1'b0, in_measured});
    assign acc_wide  = (SumWidth+1)'(error_sum_reg) + (SumWidth+1)'(err_next);
    assign rate_next = RateWidth'(err_next) - RateWidth'(last_error_reg);

    always_comb
    begin
        if (acc_wide[SumWidth] != acc_wide[SumWidth-1])
        begin
            acc_next = {acc_wide[SumWidth], {(SumWidth-1){!acc_wide[SumWidth]}}};
        end
        else
        begin
            acc_next = acc_wide[SumWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deriv_gain_reg <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            trim_hold_reg  <= TrimMid;
            vld_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                deriv_gain_reg <= cfg_data;
            end
            if (s_accept && in_enable)
            begin
                error_sum_reg  <= acc_next;
                last_error_reg <= err_next;
            end
            if (load[NumStages-1] && en4_reg)
            begin
                trim_hold_reg <= trim_next;
            end
            vld_reg[0] <= can_load[0] ? s_axis_tvalid : vld_reg[0];
            for (int k = 1; k < NumStages; k++)
            begin
                vld_reg[k] <= can_load[k] ? vld_reg[k-1] : vld_reg[k];
            end
        end
    end

    assign term_ctl.prod_en = load[1];
    assign term_ctl.quot_en = load[2];

    afrpid_term u_term_p (
        .clk   (clk),
        .ctl   (term_ctl),
        .value (SumWidth'(err1_reg)),
        .gain  (pg1_reg),
        .term  (term_p)
    );

    afrpid_term u_term_i (
        .clk   (clk),
        .ctl   (term_ctl),
        .value (acc1_reg),
        .gain  (ig1_reg),
        .term  (term_i)
    );

    afrpid_term u_term_d (
        .clk   (clk),
        .ctl   (term_ctl),
        .value (SumWidth'(rate1_reg)),
        .gain  (deriv_gain_reg),
        .term  (term_d)
    );

    assign sum4_next = TotWidth'(term_p) + TotWidth'(term_i) + TotWidth'(term_d);

    // Division by 16 truncates toward zero.
    assign sum_adj = sum4_reg[TotWidth-1] ? sum4_reg + TotWidth'(15) : sum4_reg;
    assign sum_div = sum_adj >>> 4;

    always_comb
    begin
        if (sum_div < -TotWidth'(32))
        begin
            trim_next = TrimLow;
        end
        else if (sum_div > TotWidth'(32))
        begin
            trim_next = TrimHigh;
        end
        else
        begin
            trim_next = sum_div[7:0] + TrimMid;
        end
        trim_out_next = en4_reg ? trim_next : trim_hold_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            en1_reg   <= in_enable;
            err1_reg  <= err_next;
            acc1_reg  <= acc_next;
            rate1_reg <= rate_next;
            pg1_reg   <= in_pg;
            ig1_reg   <= in_ig;
        end
        if (load[1])
        begin
            en2_reg <= en1_reg;
        end
        if (load[2])
        begin
            en3_reg <= en2_reg;
        end
        if (load[3])
        begin
            en4_reg  <= en3_reg;
            sum4_reg <= sum4_next;
        end
        if (load[4])
        begin
            trim_out_reg <= trim_out_next;
            upd_out_reg  <= en4_reg;
        end
    end

    assign m_axis_tvalid = vld_reg[NumStages-1];
    assign m_axis_tdata  = {7'd0, upd_out_reg, trim_out_reg};

endmodule

/* tb/afr_pid_fuel_trim_checker.sv */
module afr_pid_fuel_trim_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [afrpid_pkg::GainWidth-1:0]   cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [afrpid_pkg::InWidth-1:0]     s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [afrpid_pkg::OutWidth-1:0]    m_axis_tdata,
    output int                                 errors,
    output int                                 pending
);

    typedef struct packed {
        logic [7:0] fuel_trim;
        logic       updated;
    } trim_beat_t;

    logic [afrpid_pkg::GainWidth-1:0] deriv_gain;
    logic signed [23:0]               integ_sum;
    logic signed [12:0]               prev_error;
    logic [7:0]                       trim_hold;
    trim_beat_t                       trim_queue[$];
    trim_beat_t                       oldest_trim;
    int                               mismatch_count;

    assign errors = mismatch_count;

    function automatic longint scale_by_gain(input longint value, input logic [7:0] gain);
        return (value * longint'(gain)) / 255;
    endfunction

    function automatic trim_beat_t predict_trim(input logic [afrpid_pkg::InWidth-1:0] beat);
        trim_beat_t result;
        longint     err;
        longint     acc;
        longint     rate;
        longint     total;
        longint     trim;
        err = longint'(beat[12:1]) - longint'(beat[24:13]);
        if (beat[0])
        begin
            acc = longint'(integ_sum) + err;
            rate = err - longint'(prev_error);
            if (acc > 64'sd8388607)
            begin
                acc = 64'sd8388607;
            end
            else if (acc < -64'sd8388608)
            begin
                acc = -64'sd8388608;
            end
            integ_sum = acc[23:0];
            prev_error = err[12:0];
            total = scale_by_gain(err, beat[32:25]) + scale_by_gain(acc, beat[40:33])
                  + scale_by_gain(rate, deriv_gain);
            trim = longint'(afrpid_pkg::TrimMid) + total / 16;
            if (trim < longint'(afrpid_pkg::TrimLow))
            begin
                trim = longint'(afrpid_pkg::TrimLow);
            end
            else if (trim > longint'(afrpid_pkg::TrimHigh))
            begin
                trim = longint'(afrpid_pkg::TrimHigh);
            end
            trim_hold = trim[7:0];
        end
        result.fuel_trim = trim_hold;
        result.updated = beat[0];
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deriv_gain = '0;
            integ_sum = '0;
            prev_error = '0;
            trim_hold = afrpid_pkg::TrimMid;
            trim_queue.delete();
            mismatch_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                deriv_gain = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                trim_queue.push_back(predict_trim(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (trim_queue.size() == 0)
                begin
                    $error("unexpected result beat: fuel_trim %0d updated %0d",
                           m_axis_tdata[7:0], m_axis_tdata[8]);
                    mismatch_count++;
                end
                else
                begin
                    oldest_trim = trim_queue.pop_front();
                    if (m_axis_tdata[7:0] !== oldest_trim.fuel_trim)
                    begin
                        $error("fuel_trim mismatch: expected %0d, actual %0d",
                               oldest_trim.fuel_trim, m_axis_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[8] !== oldest_trim.updated)
                    begin
                        $error("updated mismatch: expected %0d, actual %0d",
                               oldest_trim.updated, m_axis_tdata[8]);
                        mismatch_count++;
                    end
                end
            end
            pending <= trim_queue.size();
        end
    end

endmodule

/* tb/afr_pid_fuel_trim_core_tb.sv */
module afr_pid_fuel_trim_core_tb;

    localparam int IdleLimit = 4000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [afrpid_pkg::GainWidth-1:0]   cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [afrpid_pkg::InWidth-1:0]     s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [afrpid_pkg::OutWidth-1:0]    m_axis_tdata;

    int errors;
    int pending;
    int burst_left = 0;
    int ticks_sent = 0;
    int ticks_held = 0;
    int results_seen = 0;
    int gain_writes = 0;
    int idle_cycles = 0;
    int rx_left = 0;
    logic rx_toggle = 1'b0;

    always #6 clk = ~clk;

    afr_pid_fuel_trim_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    afr_pid_fuel_trim_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    function automatic logic [afrpid_pkg::InWidth-1:0] pack_tick(
        input logic en, input logic [11:0] tgt, input logic [11:0] meas,
        input logic [7:0] pg, input logic [7:0] ig);
        return {7'd0, ig, pg, meas, tgt, en};
    endfunction

    function automatic logic [afrpid_pkg::InWidth-1:0] random_tick();
        int   kind;
        logic [11:0] tgt;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            tgt = 12'($urandom_range(1300, 1600));
            return pack_tick(1'b1, tgt, 12'(tgt + $urandom_range(0, 400) - 200),
                             8'($urandom), 8'($urandom));
        end
        else if (kind < 17)
        begin
            return pack_tick(1'b0, 12'($urandom), 12'($urandom), 8'($urandom),
                             8'($urandom));
        end
        return pack_tick(1'($urandom), 12'($urandom), 12'($urandom), 8'($urandom),
                         8'($urandom));
    endfunction

    task automatic send_tick(input logic [afrpid_pkg::InWidth-1:0] beat);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        burst_left--;
        ticks_sent++;
        if (!beat[0])
        begin
            ticks_held++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_deriv_gain(input logic [afrpid_pkg::GainWidth-1:0] gain);
        cfg_valid <= 1'b1;
        cfg_data <= gain;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        gain_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    rx_toggle = 1'b0;
                    m_axis_tready <= 1'b0;
                    rx_left = $urandom_range(1, 12);
                end
                1:
                begin
                    rx_toggle = 1'b1;
                    m_axis_tready <= ~m_axis_tready;
                    rx_left = $urandom_range(4, 16);
                end
                default:
                begin
                    rx_toggle = 1'b0;
                    m_axis_tready <= 1'b1;
                    rx_left = $urandom_range(1, 60);
                end
            endcase
        end
        else
        begin
            rx_left--;
            if (rx_toggle)
            begin
                m_axis_tready <= ~m_axis_tready;
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Timeout after %0d cycles without a beat", IdleLimit);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int   phase;
        logic [7:0] gain;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_deriv_gain(8'd255);
        send_tick(pack_tick(1'b0, 12'd0, 12'd0, 8'd0, 8'd0));
        send_tick(pack_tick(1'b0, 12'd4095, 12'd4095, 8'd255, 8'd255));
        send_tick(pack_tick(1'b1, 12'd4095, 12'd0, 8'd255, 8'd255));
        send_tick(pack_tick(1'b1, 12'd0, 12'd4095, 8'd255, 8'd255));
        send_tick(pack_tick(1'b0, 12'd1234, 12'd3210, 8'd17, 8'd200));
        send_tick(pack_tick(1'b1, 12'd1470, 12'd1470, 8'd0, 8'd0));
        send_tick(pack_tick(1'b1, 12'd1470, 12'd1470, 8'd255, 8'd0));
        send_tick(pack_tick(1'b1, 12'd1470, 12'd1400, 8'd255, 8'd0));
        send_tick(pack_tick(1'b1, 12'd1400, 12'd1470, 8'd255, 8'd0));
        send_tick(pack_tick(1'b1, 12'd0, 12'd0, 8'd0, 8'd0));
        send_tick(pack_tick(1'b1, 12'd4095, 12'd4095, 8'd255, 8'd255));
        send_tick(pack_tick(1'b1, 12'd1470, 12'd1500, 8'd1, 8'd1));
        send_tick(pack_tick(1'b1, 12'd2048, 12'd2047, 8'd128, 8'd128));
        send_tick(pack_tick(1'b1, 12'd2047, 12'd2048, 8'd127, 8'd254));
        send_tick(pack_tick(1'b1, 12'd1470, 12'd1717, 8'd255, 8'd1));
        send_tick(pack_tick(1'b0, 12'd0, 12'd4095, 8'd0, 8'd255));
        send_tick(pack_tick(1'b1, 12'd1470, 12'd1470, 8'd0, 8'd255));
        wait_drained();

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: gain = 8'd0;
                1: gain = 8'd1;
                2: gain = 8'd255;
                default: gain = 8'($urandom_range(2, 254));
            endcase
            write_deriv_gain(gain);
            repeat (240)
            begin
                send_tick(random_tick());
                if (phase == 1 && ticks_sent % 150 == 0)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        write_deriv_gain(8'($urandom));
        repeat (200)
        begin
            send_tick(pack_tick(1'($urandom_range(0, 15) != 0),
                                12'($urandom_range(4091, 4095)), 12'($urandom_range(0, 4)),
                                8'($urandom), 8'($urandom)));
        end
        repeat (200)
        begin
            send_tick(pack_tick(1'($urandom_range(0, 15) != 0),
                                12'($urandom_range(0, 4)), 12'($urandom_range(4091, 4095)),
                                8'($urandom), 8'($urandom)));
        end
        wait_drained();

        write_deriv_gain(8'd128);
        repeat (100)
        begin
            send_tick(random_tick());
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d control ticks (%0d held), checked %0d trim results", ticks_sent,
                 ticks_held, results_seen);
        $display("Used %0d derivative gain settings, including long full-scale error runs",
                 gain_writes);
        if (errors == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
